/* rtl/core/rlref_pkg.sv */
package rlref_pkg;

    // Fixed field widths.
    localparam int START_W = 10;
    localparam int EDGE_W  = 10;
    localparam int CFG_W   = 11;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes, taken from paddr above the byte offset.
    localparam logic [PADDR_W-3:0] REG_ROW_WIDTH = 1'b0;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 11'd640;

    typedef struct packed {
        logic [START_W-1:0] start_col;
        logic               pixel_white;
    } t_pixel_word;

    typedef struct packed {
        logic              found;
        logic [EDGE_W-1:0] left_edge;
        logic [EDGE_W-1:0] right_edge;
    } t_result_word;

    // Top level to tracker: one pixel word that advances this cycle.
    typedef struct packed {
        logic        enable;
        t_pixel_word word;
    } t_step_cmd;

    // Tracker to top level: whether the held pixel closes its row, and the row result.
    typedef struct packed {
        logic         last;
        t_result_word result;
    } t_step_status;

endpackage

/* rtl/core/rlref_if.sv */
interface rlref_in_if;
    import rlref_pkg::*;

    logic               valid;
    logic               ready;
    logic [START_W-1:0] start_col;
    logic               pixel_white;

    modport source (output valid, output start_col, output pixel_white, input ready);
    modport sink   (input valid, input start_col, input pixel_white, output ready);
endinterface

interface rlref_out_if;
    import rlref_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [EDGE_W-1:0] left_edge;
    logic [EDGE_W-1:0] right_edge;

    modport source (output valid, output found, output left_edge, output right_edge,
                    input ready);
    modport sink   (input valid, input found, input left_edge, input right_edge,
                    output ready);
endinterface

/* rtl/core/rlref_tracker.sv */
module rlref_tracker #(
    parameter int MAX_COLS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rlref_pkg::t_step_cmd               i_cmd,
    input  logic [$clog2(MAX_COLS + 1) - 1:0]  i_width,
    output rlref_pkg::t_step_status            o_status
);
    import rlref_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int EW = $clog2(MAX_COLS + 1);
    localparam int SW = (EW > START_W) ? EW : START_W;

    logic [CW-1:0]      r_col;
    logic [START_W-1:0] r_start;
    logic [CW-1:0]      r_run_start;
    logic               r_prev;
    logic               r_center;
    logic               r_lvalid;
    logic [CW-1:0]      r_lcol;
    logic [CW-1:0]      r_lrun;
    logic               r_rvalid;
    logic [CW-1:0]      r_rcol;
    logic [CW-1:0]      r_end;
    logic               r_end_seen;

    logic [START_W-1:0] n_start;
    logic [CW-1:0]      n_run_start;
    logic               n_prev;
    logic               n_center;
    logic               n_lvalid;
    logic [CW-1:0]      n_lcol;
    logic [CW-1:0]      n_lrun;
    logic               n_rvalid;
    logic [CW-1:0]      n_rcol;
    logic [CW-1:0]      n_end;
    logic               n_end_seen;

    logic [SW-1:0]      col_ext;
    logic [SW-1:0]      start_ext;
    logic [CW-1:0]      run_begin;
    logic [EW-1:0]      col_plus1;
    logic               pix;
    logic               last;
    logic [SW-1:0]      dist_left;
    logic [SW-1:0]      dist_right;
    logic               take_left;
    logic               found;
    logic [CW-1:0]      le;
    logic [CW-1:0]      re;

    always_comb begin
        pix       = i_cmd.word.pixel_white;
        n_start   = (r_col == '0) ? i_cmd.word.start_col : r_start;
        col_ext   = SW'(r_col);
        start_ext = SW'(n_start);
        run_begin = (r_prev && (r_col != '0)) ? r_run_start : r_col;

        n_run_start = pix ? run_begin : r_run_start;
        n_prev      = pix;
        n_center    = r_center;
        n_lvalid    = r_lvalid;
        n_lcol      = r_lcol;
        n_lrun      = r_lrun;
        n_rvalid    = r_rvalid;
        n_rcol      = r_rcol;
        n_end       = r_end;
        n_end_seen  = r_end_seen;

        priority if (col_ext < start_ext) begin
            if (pix) begin
                n_lvalid = 1'b1;
                n_lcol   = r_col;
                n_lrun   = run_begin;
            end
        end else if (col_ext == start_ext) begin
            n_center = pix;
            if (pix) begin
                n_lrun = run_begin;
                n_end  = r_col;
            end
        end else begin
            // Right of the start: first look for the nearest white pixel,
            // then follow its run (or the start's run) to its end.
            if (!r_center && !r_rvalid) begin
                if (pix) begin
                    n_rvalid = 1'b1;
                    n_rcol   = r_col;
                    n_end    = r_col;
                end
            end else if (!r_end_seen) begin
                if (pix) begin
                    n_end = r_col;
                end else begin
                    n_end_seen = 1'b1;
                end
            end
        end

        col_plus1 = EW'(r_col) + EW'(1);
        last      = (col_plus1 >= i_width);

        dist_left  = start_ext - SW'(n_lcol);
        dist_right = SW'(n_rcol) - start_ext;
        take_left  = (n_lvalid && n_rvalid) ? (dist_left <= dist_right) : n_lvalid;

        found = 1'b0;
        le    = '0;
        re    = '0;
        if (start_ext < SW'(i_width)) begin
            if (n_center) begin
                found = 1'b1;
                le    = n_lrun;
                re    = n_end;
            end else if (n_lvalid || n_rvalid) begin
                found = 1'b1;
                if (take_left) begin
                    le = n_lrun;
                    re = n_lcol;
                end else begin
                    le = n_rcol;
                    re = n_end;
                end
            end
        end

        o_status.last              = last;
        o_status.result.found      = found;
        o_status.result.left_edge  = found ? EDGE_W'(le) : '0;
        o_status.result.right_edge = found ? EDGE_W'(re) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.enable && last)) begin
            r_col       <= '0;
            r_start     <= '0;
            r_run_start <= '0;
            r_prev      <= 1'b0;
            r_center    <= 1'b0;
            r_lvalid    <= 1'b0;
            r_lcol      <= '0;
            r_lrun      <= '0;
            r_rvalid    <= 1'b0;
            r_rcol      <= '0;
            r_end       <= '0;
            r_end_seen  <= 1'b0;
        end else if (i_cmd.enable) begin
            r_col       <= CW'(col_plus1);
            r_start     <= n_start;
            r_run_start <= n_run_start;
            r_prev      <= n_prev;
            r_center    <= n_center;
            r_lvalid    <= n_lvalid;
            r_lcol      <= n_lcol;
            r_lrun      <= n_lrun;
            r_rvalid    <= n_rvalid;
            r_rcol      <= n_rcol;
            r_end       <= n_end;
            r_end_seen  <= n_end_seen;
        end
    end

endmodule

/* rtl/core/row_line_run_edge_finder_top.sv */
// Row run edge finder. Pixels of one binarized row stream in left to right, one word
// per pixel, and the start column is taken from the first word of each row. When the
// word at column row_width-1 is taken, the block emits one result word: the white run
// that holds the start column, or else the run of the nearest white pixel, with ties
// going to the left. A start beyond the row, or a row without a usable white pixel,
// gives found=0 and both edges 0. The block takes one pixel word per clock without a
// break between rows; each word passes an input register, one pass of run-tracking
// logic and, for the last pixel of a row, a result register, which holds the result
// word until it is taken. The input stalls only when a row ends while the previous
// result word still waits at the output. row_width is written through the APB port
// at byte address 0 (reset value 640; 0 acts as 1 and values above MAX_COLS act as
// MAX_COLS) and should be changed only between rows.
module row_line_run_edge_finder_top #(
    parameter int MAX_COLS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rlref_pkg::PADDR_W-1:0]        paddr,
    input  logic [rlref_pkg::PDATA_W-1:0]        pwdata,
    output logic [rlref_pkg::PDATA_W-1:0]        prdata,
    output logic                                 pready,
    rlref_in_if.sink                             i_pix,
    rlref_out_if.source                          o_res
);
    import rlref_pkg::*;

    localparam int EW = $clog2(MAX_COLS + 1);
    localparam int RW = (EW > CFG_W) ? EW : CFG_W;

    // Configuration register.
    logic [CFG_W-1:0]       r_row_width;
    logic [PADDR_W-3:0]     reg_idx;
    logic                   cfg_write;
    logic [RW-1:0]          width_ext;
    logic [EW-1:0]          width_eff;

    // Input register in front of the tracker.
    logic                   r_in_valid;
    t_pixel_word            r_in_word;

    // Result register toward the output channel.
    logic                   r_out_valid;
    t_result_word           r_out_word;

    t_step_cmd              step_cmd;
    t_step_status           step_status;
    logic                   advance;
    logic                   in_ready;

    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && (reg_idx == REG_ROW_WIDTH);
    assign pready    = 1'b1;
    assign prdata    = (reg_idx == REG_ROW_WIDTH) ? PDATA_W'(r_row_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RESET;
        end else if (cfg_write) begin
            r_row_width <= pwdata[CFG_W-1:0];
        end
    end

    // Clamp the programmed width into the range the column counter supports.
    always_comb begin
        width_ext = RW'(r_row_width);
        if (width_ext == '0) begin
            width_eff = EW'(1);
        end else if (width_ext > RW'(MAX_COLS)) begin
            width_eff = EW'(MAX_COLS);
        end else begin
            width_eff = EW'(width_ext);
        end
    end

    // The held pixel moves on unless it closes a row while the result register is
    // still occupied by an untaken word.
    assign advance  = r_in_valid && (!step_status.last || !r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || advance;
    assign i_pix.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_pix.valid) begin
            r_in_word.start_col   <= i_pix.start_col;
            r_in_word.pixel_white <= i_pix.pixel_white;
        end
    end

    assign step_cmd.enable = advance;
    assign step_cmd.word   = r_in_word;

    rlref_tracker #(
        .MAX_COLS (MAX_COLS)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (step_cmd),
        .i_width  (width_eff),
        .o_status (step_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_status.last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_status.last) begin
            r_out_word <= step_status.result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.found      = r_out_word.found;
    assign o_res.left_edge  = r_out_word.left_edge;
    assign o_res.right_edge = r_out_word.right_edge;

endmodule

/* rtl/core/rlref_checker.sv */
module rlref_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_found,
    input logic [rlref_pkg::EDGE_W-1:0]   i_left_edge,
    input logic [rlref_pkg::EDGE_W-1:0]   i_right_edge
);
    import rlref_pkg::*;

    // A waiting result word keeps its contents until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_found) && $stable(i_left_edge)
             && $stable(i_right_edge)))
        else $error("result word changed while stalled");

    // The pixel input only backs up behind a stalled result word.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    // A row without a run reports zero edges.
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> ((i_left_edge == '0) && (i_right_edge == '0)))
        else $error("edges nonzero on a row without a run");

    // No result word right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind row_line_run_edge_finder_top rlref_checker u_rlref_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_found      (o_res.found),
    .i_left_edge  (o_res.left_edge),
    .i_right_edge (o_res.right_edge)
);
